// ----- rtl/core/mssd_pkg.sv -----
// Shared types, constants and glyph decode for the seven-segment number display.
`timescale 1ns / 1ps

package mssd_pkg;

    localparam int NUM_W   = 14;
    localparam int SEG_W   = 7;
    localparam int SEL_W   = 4;
    localparam int NDIGITS = 4;

    localparam logic [NUM_W-1:0] MAX_VALUE_RESET = 14'd2000;

    // Reciprocal multipliers: exact quotients over the full input range.
    localparam logic [13:0] RECIP_1000 = 14'd8389;   // >> 23
    localparam logic [5:0]  RECIP_100  = 6'd41;      // >> 12
    localparam logic [7:0]  RECIP_10   = 8'd205;     // >> 11

    localparam logic [9:0]  K1000 = 10'd1000;
    localparam logic [6:0]  K100  = 7'd100;
    localparam logic [3:0]  K10   = 4'd10;

    typedef logic [SEG_W-1:0] seg_t;

    // One queued item: segment patterns for thousands, hundreds, tens, ones.
    typedef struct packed {
        seg_t [NDIGITS-1:0] glyph;
    } mssd_entry_t;

    function automatic seg_t glyph_of(input logic [4:0] d);
        seg_t g;
        begin
            g = '0;
            unique case (d)
                5'd0:    g = 7'h3F;
                5'd1:    g = 7'h06;
                5'd2:    g = 7'h5B;
                5'd3:    g = 7'h4F;
                5'd4:    g = 7'h66;
                5'd5:    g = 7'h6D;
                5'd6:    g = 7'h7D;
                5'd7:    g = 7'h07;
                5'd8:    g = 7'h7F;
                5'd9:    g = 7'h67;
                default: g = 7'h00;
            endcase
            return g;
        end
    endfunction

endpackage

// ----- rtl/core/mssd_front.sv -----
// Front end: accepts numbers, range check, decimal split, blanking, credit count.
`timescale 1ns / 1ps

module mssd_front #(
    parameter int QDEPTH = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [mssd_pkg::NUM_W-1:0] number,
    input  logic                      max_value_we,
    input  logic [mssd_pkg::NUM_W-1:0] max_value_wdata,
    input  logic                      pop,
    output logic                      push,
    output mssd_pkg::mssd_entry_t     push_entry
);
    import mssd_pkg::*;

    localparam int CNT_W = $clog2(QDEPTH + 1);

    logic [NUM_W-1:0] max_value_reg;
    logic [CNT_W-1:0] credit_reg, credit_next;

    logic accept, take;

    logic [5:0] v_reg;

    logic [NUM_W-1:0] n0_reg, n1_reg;
    logic [4:0]       th1_reg, th2_reg, th3_reg, th4_reg, th5_reg;
    logic [9:0]       rem2_reg, rem3_reg;
    logic [3:0]       hu3_reg, hu4_reg, hu5_reg;
    logic [6:0]       r4_reg;
    logic [3:0]       te5_reg, on5_reg;

    logic [27:0] prod_th;
    logic [14:0] diff_th;
    logic [15:0] prod_hu;
    logic [9:0]  diff_hu;
    logic [14:0] prod_te;
    logic [6:0]  diff_te;

    logic lead1, lead2;

    assign busy   = (credit_reg == CNT_W'(QDEPTH));
    assign accept = start && !busy;
    assign take   = accept && (number <= max_value_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_value_reg <= MAX_VALUE_RESET;
        end
        else if (max_value_we)
        begin
            max_value_reg <= max_value_wdata;
        end
    end

    // Slots held by items in the pipe or the queue; freed when the back end pops.
    always_comb
    begin
        credit_next = credit_reg;
        if (take && !pop)
        begin
            credit_next = credit_reg + CNT_W'(1);
        end
        else if (!take && pop)
        begin
            credit_next = credit_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
            v_reg      <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
            v_reg      <= {v_reg[4:0], take};
        end
    end

    assign prod_th = 28'(n0_reg) * 28'(RECIP_1000);
    assign diff_th = 15'(n1_reg) - 15'(th1_reg) * 15'(K1000);
    assign prod_hu = 16'(rem2_reg) * 16'(RECIP_100);
    assign diff_hu = rem3_reg - 10'(hu3_reg) * 10'(K100);
    assign prod_te = 15'(r4_reg) * 15'(RECIP_10);
    assign diff_te = r4_reg - 7'(prod_te[14:11]) * 7'(K10);

    always_ff @(posedge clk)
    begin
        n0_reg   <= number;
        n1_reg   <= n0_reg;
        th1_reg  <= prod_th[27:23];
        th2_reg  <= th1_reg;
        rem2_reg <= diff_th[9:0];
        th3_reg  <= th2_reg;
        rem3_reg <= rem2_reg;
        hu3_reg  <= prod_hu[15:12];
        th4_reg  <= th3_reg;
        hu4_reg  <= hu3_reg;
        r4_reg   <= diff_hu[6:0];
        th5_reg  <= th4_reg;
        hu5_reg  <= hu4_reg;
        te5_reg  <= prod_te[14:11];
        on5_reg  <= diff_te[3:0];
    end

    // th1 is taken from n0, so it lands in the same cycle as n1 for the remainder.

    // Leading zeros blank; a thousands value above nine still counts as nonzero.
    assign lead1 = (th5_reg == 5'd0) && (hu5_reg == 4'd0);
    assign lead2 = lead1 && (te5_reg == 4'd0);

    assign push = v_reg[5];
    assign push_entry.glyph[0] = (th5_reg == 5'd0) ? '0 : glyph_of(th5_reg);
    assign push_entry.glyph[1] = lead1 ? '0 : glyph_of({1'b0, hu5_reg});
    assign push_entry.glyph[2] = lead2 ? '0 : glyph_of({1'b0, te5_reg});
    assign push_entry.glyph[3] = glyph_of({1'b0, on5_reg});

endmodule

// ----- rtl/core/mssd_queue.sv -----
// Small FIFO between the front end and the digit sequencer.
`timescale 1ns / 1ps

module mssd_queue #(
    parameter int QDEPTH = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  mssd_pkg::mssd_entry_t push_entry,
    input  logic                  pop,
    output logic                  not_empty,
    output mssd_pkg::mssd_entry_t head
);
    import mssd_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    mssd_entry_t mem [QDEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        begin
            return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
        end
    endfunction

    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!push && pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- rtl/core/mssd_back.sv -----
// Back end: plays one queued item out as four digit results.
`timescale 1ns / 1ps

module mssd_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        not_empty,
    input  mssd_pkg::mssd_entry_t       head,
    output logic                        pop,
    output logic                        strobe,
    output logic [mssd_pkg::SEL_W-1:0]  digit_select,
    output logic [mssd_pkg::SEG_W-1:0]  segments,
    output logic                        last_digit
);
    import mssd_pkg::*;

    logic        active_reg, active_next;
    logic [1:0]  pos_reg, pos_next;
    mssd_entry_t cur_reg;

    logic             strobe_reg;
    logic [SEL_W-1:0] sel_reg;
    seg_t             seg_reg;
    logic             last_reg;

    logic done;

    assign done = !active_reg || (pos_reg == 2'd3);
    assign pop  = done && not_empty;

    always_comb
    begin
        active_next = active_reg;
        pos_next    = pos_reg;
        if (pop)
        begin
            active_next = 1'b1;
            pos_next    = 2'd0;
        end
        else if (done)
        begin
            active_next = 1'b0;
        end
        else
        begin
            pos_next = pos_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pos_reg    <= 2'd0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            pos_reg    <= pos_next;
            strobe_reg <= active_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
        sel_reg  <= ~(SEL_W'(1) << pos_reg);
        seg_reg  <= cur_reg.glyph[pos_reg];
        last_reg <= (pos_reg == 2'd3);
    end

    assign strobe       = strobe_reg;
    assign digit_select = sel_reg;
    assign segments     = seg_reg;
    assign last_digit   = last_reg;

endmodule

// ----- rtl/core/multiplexed_seven_segment_number_display_top.sv -----
// Top level of the four-digit seven-segment number display.
`timescale 1ns / 1ps

// A number is taken at a clock edge where start is high and busy is low. If it is
// above max_value it is dropped with no results. Otherwise four results follow
// on consecutive cycles, each marked by strobe: thousands, hundreds, tens, ones,
// with last_digit set on the ones result. The receiver cannot stall, so strobe
// results must be captured when shown. Sustained throughput is set by the digit
// sequencer emitting one result per cycle; up to QDEPTH numbers may be taken
// ahead of it, after which busy holds until the sequencer frees a queue slot.
// The user must write max_value with max_value_we and max_value_wdata only while
// the block is idle; the block itself does not enforce this.
module multiplexed_seven_segment_number_display_top #(
    parameter int QDEPTH = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [mssd_pkg::NUM_W-1:0]  number,
    input  logic                        max_value_we,
    input  logic [mssd_pkg::NUM_W-1:0]  max_value_wdata,
    output logic                        strobe,
    output logic [mssd_pkg::SEL_W-1:0]  digit_select,
    output logic [mssd_pkg::SEG_W-1:0]  segments,
    output logic                        last_digit
);
    import mssd_pkg::*;

    logic        push, pop, not_empty;
    mssd_entry_t push_entry, head;

    mssd_front #(
        .QDEPTH(QDEPTH)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .number          (number),
        .max_value_we    (max_value_we),
        .max_value_wdata (max_value_wdata),
        .pop             (pop),
        .push            (push),
        .push_entry      (push_entry)
    );

    mssd_queue #(
        .QDEPTH(QDEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .not_empty  (not_empty),
        .head       (head)
    );

    mssd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .not_empty    (not_empty),
        .head         (head),
        .pop          (pop),
        .strobe       (strobe),
        .digit_select (digit_select),
        .segments     (segments),
        .last_digit   (last_digit)
    );

endmodule

// ----- test/multiplexed_seven_segment_number_display_top_test.sv -----
// Testbench for the seven-segment number display: directed and random numbers against a digit predictor.
`timescale 1ns / 1ps

class digit_scoreboard;

    typedef enum int {POS_THOUSANDS, POS_HUNDREDS, POS_TENS, POS_ONES} digit_pos_e;

    typedef struct {
        logic [mssd_pkg::SEL_W-1:0] select;
        mssd_pkg::seg_t             segs;
        logic                       last;
    } digit_t;

    digit_t                     pending_digits[$];
    logic [mssd_pkg::NUM_W-1:0] max_value;
    int                         mismatches;

    function new();
        max_value  = mssd_pkg::MAX_VALUE_RESET;
        mismatches = 0;
    endfunction

    // Digits above nine (thousands with a wide max_value) have no glyph.
    function mssd_pkg::seg_t digit_glyph(int unsigned d);
        case (d)
            0:       return 7'h3F;
            1:       return 7'h06;
            2:       return 7'h5B;
            3:       return 7'h4F;
            4:       return 7'h66;
            5:       return 7'h6D;
            6:       return 7'h7D;
            7:       return 7'h07;
            8:       return 7'h7F;
            9:       return 7'h67;
            default: return 7'h00;
        endcase
    endfunction

    function void push_digit(digit_pos_e pos, mssd_pkg::seg_t segs);
        digit_t d;
        d.select = ~(4'b0001 << pos);
        d.segs   = segs;
        d.last   = (pos == POS_ONES);
        pending_digits.push_back(d);
    endfunction

    // Accepted number: queue its four digits unless it is over the limit.
    function void note_number(logic [mssd_pkg::NUM_W-1:0] n);
        int unsigned thousands, hundreds, tens, ones;
        bit          blank;
        if (n > max_value)
            return;
        thousands = n / 1000;
        hundreds  = (n / 100) % 10;
        tens      = (n / 10) % 10;
        ones      = n % 10;
        blank = (thousands == 0);
        push_digit(POS_THOUSANDS, blank ? '0 : digit_glyph(thousands));
        blank = blank && (hundreds == 0);
        push_digit(POS_HUNDREDS, blank ? '0 : digit_glyph(hundreds));
        blank = blank && (tens == 0);
        push_digit(POS_TENS, blank ? '0 : digit_glyph(tens));
        push_digit(POS_ONES, digit_glyph(ones));
    endfunction

    function void check_digit(logic [mssd_pkg::SEL_W-1:0] sel, mssd_pkg::seg_t segs,
                              logic last);
        digit_t want;
        if (pending_digits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected digit: sel=%h seg=%h last=%b", sel, segs, last);
            return;
        end
        want = pending_digits.pop_front();
        if (sel !== want.select || segs !== want.segs || last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
                $display("digit mismatch: expected sel=%h seg=%h last=%b, got sel=%h seg=%h last=%b",
                         want.select, want.segs, want.last, sel, segs, last);
        end
    endfunction

    function void flush_missing();
        while (pending_digits.size() != 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("missing digit: expected sel=%h seg=%h last=%b",
                         pending_digits[0].select, pending_digits[0].segs,
                         pending_digits[0].last);
            void'(pending_digits.pop_front());
        end
    endfunction

endclass

module multiplexed_seven_segment_number_display_top_test;

    import mssd_pkg::*;

    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          DRAIN_LIMIT   = 2000;
    localparam int          MAX_GAP       = 40;
    localparam int unsigned NUM_MAX       = (1 << NUM_W) - 1;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [NUM_W-1:0] number;
    logic             max_value_we;
    logic [NUM_W-1:0] max_value_wdata;
    logic             strobe;
    logic [SEL_W-1:0] digit_select;
    logic [SEG_W-1:0] segments;
    logic             last_digit;

    digit_scoreboard digits_sb = new();
    int              cycle_count = 0;

    int unsigned reset_cases[$] = '{0, 1, 9, 10, 99, 100, 101, 999, 1000, 1005, 1999, 2000,
                                    2001, 16383};
    int unsigned wide_cases[$]  = '{9999, 10000, 10050, 16000, 16383, 8765};
    int unsigned zero_cases[$]  = '{0, 1};

    multiplexed_seven_segment_number_display_top i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .number          (number),
        .max_value_we    (max_value_we),
        .max_value_wdata (max_value_wdata),
        .strobe          (strobe),
        .digit_select    (digit_select),
        .segments        (segments),
        .last_digit      (last_digit)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Outputs are read before this edge's updates land.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                digits_sb.note_number(number);
            if (strobe)
                digits_sb.check_digit(digit_select, segments, last_digit);
        end
    end

    task automatic write_max_value(input logic [NUM_W-1:0] v);
        max_value_we    <= 1'b1;
        max_value_wdata <= v;
        @(posedge clk);
        max_value_we    <= 1'b0;
        digits_sb.max_value = v;
    endtask

    // start stays high after acceptance so back-to-back items need no gap.
    task automatic send_number(input logic [NUM_W-1:0] n, input int idle_pct);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap)
            begin
                number <= NUM_W'($urandom_range(NUM_MAX));
                @(posedge clk);
            end
        end
        start  <= 1'b1;
        number <= n;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Digits the predictor did not expect may still be in flight after the last expected one, hence the settle time.
    task automatic wait_drained();
        int waited;
        waited = 0;
        start <= 1'b0;
        while (digits_sb.pending_digits.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        digits_sb.flush_missing();
    endtask

    function automatic logic [NUM_W-1:0] pick_number(input int unsigned maxv);
        int unsigned r, lo, hi, top;
        r = $urandom_range(99);
        if (r < 45)
            return NUM_W'($urandom_range(maxv, 0));
        if (r < 60)
            return NUM_W'($urandom_range(maxv < 120 ? maxv : 120, 0));
        if (r < 72)
        begin
            // sparse digits exercise blanking around inner zeros
            top = maxv / 1000;
            return NUM_W'(($urandom_range(1) ? 0 : $urandom_range(top)) * 1000
                          + ($urandom_range(1) ? 0 : $urandom_range(9)) * 100
                          + ($urandom_range(1) ? 0 : $urandom_range(9)) * 10
                          + $urandom_range(9));
        end
        if (r < 82)
        begin
            lo = (maxv < 2) ? 0 : maxv - 2;
            hi = (maxv + 2 > NUM_MAX) ? NUM_MAX : maxv + 2;
            return NUM_W'($urandom_range(hi, lo));
        end
        return NUM_W'($urandom_range(NUM_MAX));
    endfunction

    task automatic run_phase(input logic [NUM_W-1:0] maxv, input int idle_pct, input int count);
        write_max_value(maxv);
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2 && idle_pct != 0)
                wait_drained();
            send_number(pick_number(maxv), idle_pct);
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        start           <= 1'b0;
        number          <= '0;
        max_value_we    <= 1'b0;
        max_value_wdata <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limit of 2000
        foreach (reset_cases[i])
            send_number(NUM_W'(reset_cases[i]), 0);
        wait_drained();

        // limit above 9999: thousands beyond nine
        write_max_value(NUM_W'(NUM_MAX));
        foreach (wide_cases[i])
            send_number(NUM_W'(wide_cases[i]), 0);
        wait_drained();

        write_max_value('0);
        foreach (zero_cases[i])
            send_number(NUM_W'(zero_cases[i]), 0);
        wait_drained();

        run_phase(NUM_W'(9999), 0, 45);
        run_phase(NUM_W'(NUM_MAX), 64, 45);
        run_phase(NUM_W'(2000), 33, 35);
        run_phase('0, 0, 20);
        run_phase(NUM_W'($urandom_range(NUM_MAX, 1)), 33, 40);
        run_phase(NUM_W'($urandom_range(NUM_MAX, 1)), 64, 35);

        if (digits_sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
